FILE: hw/rtl/sorted_pair_sum_finder_core_defines.svh
// Assertion macros for the sorted pair sum finder.
// Used by the port checker; depends on nothing else.
`ifndef SORTED_PAIR_SUM_FINDER_CORE_DEFINES_SVH
`define SORTED_PAIR_SUM_FINDER_CORE_DEFINES_SVH

// Same-cycle implication, reset masked
`define SPSF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked
`define SPSF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/spsf_pkg.sv
// Shared constants and types for the sorted pair sum finder.
// No dependencies.
`timescale 1ns / 1ps

package spsf_pkg;

    localparam int DATA_W       = 32;
    localparam int MAX_ELEMENTS = 128;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int RESULT_LIMIT = 64;
    localparam int RES_W        = $clog2(RESULT_LIMIT + 1);

    // Controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_READ,
        ST_CMP,
        ST_FLUSH
    } state_t;

endpackage

FILE: hw/rtl/sorted_pair_sum_finder_core.sv
// Top level of the sorted pair sum finder: element store, two-pointer walk, result register.
// Depends on spsf_pkg.
`timescale 1ns / 1ps
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+--------------------------------------------
//  element   | element_valid / element_stall | element_value, last_element
//  result    | result_valid / result_stall   | left_value, right_value, no_pair, last_result
//  cfg       | cfg_valid / cfg_ready         | cfg_data (target_sum)
//
//  Loading accepts one element per cycle; elements go into a 128-entry RAM.
//  Each pointer step runs a RAM read (ST_READ), then an add and compare (ST_CMP),
//  and a set of n elements takes at most n-1 steps, plus a final check and a flush.
//  element_stall is high from the last element until the final result is registered.
//  A stalled result holds the walk only when a further result must be pushed.
//  Reset clears the control state and target_sum; the RAM is not cleared.

module sorted_pair_sum_finder_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // element channel
    input  logic                             element_valid,
    output logic                             element_stall,
    input  logic signed [spsf_pkg::DATA_W-1:0] element_value,
    input  logic                             last_element,
    // result channel
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic signed [spsf_pkg::DATA_W-1:0] left_value,
    output logic signed [spsf_pkg::DATA_W-1:0] right_value,
    output logic                             no_pair,
    output logic                             last_result,
    // configuration channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic signed [spsf_pkg::DATA_W-1:0] cfg_data
);

    localparam int DW = spsf_pkg::DATA_W;
    localparam int AW = spsf_pkg::ADDR_W;
    localparam int CW = spsf_pkg::CNT_W;
    localparam int RW = spsf_pkg::RES_W;

    spsf_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [RW-1:0] found_reg, found_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [DW-1:0] pend_left_reg, pend_left_next;
    logic [DW-1:0] pend_right_reg, pend_right_next;
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] out_left_reg, out_left_next;
    logic [DW-1:0] out_right_reg, out_right_next;
    logic          out_none_reg, out_none_next;
    logic          out_last_reg, out_last_next;
    logic [DW-1:0] target_reg, target_next;

    // element RAM and its registered read ports
    logic [DW-1:0] store_reg [0:spsf_pkg::MAX_ELEMENTS-1];
    logic [DW-1:0] lo_data_reg;
    logic [DW-1:0] hi_data_reg;

    logic          elem_acc;
    logic          store_full;
    logic          store_we;
    logic [CW-1:0] count_inc;
    logic          out_free;
    logic signed [DW:0] pair_sum;
    logic signed [DW:0] key;

    assign elem_acc   = element_valid && !element_stall;
    assign store_full = (count_reg == CW'(spsf_pkg::MAX_ELEMENTS));
    assign store_we   = elem_acc && !store_full;
    assign count_inc  = store_full ? count_reg : count_reg + CW'(1);
    assign out_free   = !out_valid_reg || !result_stall;

    // 33-bit sum and key, no overflow
    assign pair_sum = $signed({lo_data_reg[DW-1], lo_data_reg})
                    + $signed({hi_data_reg[DW-1], hi_data_reg});
    assign key      = $signed({target_reg[DW-1], target_reg});

    // RAM: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[count_reg[AW-1:0]] <= element_value;
        end
        lo_data_reg <= store_reg[lo_reg];
        hi_data_reg <= store_reg[hi_reg];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spsf_pkg::ST_LOAD;
            count_reg      <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            target_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            target_reg     <= target_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_left_reg  <= pend_left_next;
        pend_right_reg <= pend_right_next;
        out_left_reg   <= out_left_next;
        out_right_reg  <= out_right_next;
        out_none_reg   <= out_none_next;
        out_last_reg   <= out_last_next;
    end

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_left_next  = pend_left_reg;
        pend_right_next = pend_right_reg;
        out_valid_next  = out_valid_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        out_none_next   = out_none_reg;
        out_last_next   = out_last_reg;
        target_next     = target_reg;

        // request taken downstream
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            target_next = cfg_data;
        end

        case (state_reg)
            spsf_pkg::ST_LOAD:
            begin
                if (elem_acc)
                begin
                    count_next = count_inc;
                    if (last_element)
                    begin
                        lo_next         = '0;
                        hi_next         = AW'(count_inc - CW'(1));
                        found_next      = '0;
                        pend_valid_next = 1'b0;
                        state_next      = spsf_pkg::ST_READ;
                    end
                end
            end

            // RAM read under way; check that the walk goes on
            spsf_pkg::ST_READ:
            begin
                if ((lo_reg < hi_reg) && (found_reg != RW'(spsf_pkg::RESULT_LIMIT)))
                begin
                    state_next = spsf_pkg::ST_CMP;
                end
                else
                begin
                    state_next = spsf_pkg::ST_FLUSH;
                end
            end

            spsf_pkg::ST_CMP:
            begin
                if (pair_sum == key)
                begin
                    // a held pair must go out before the new one takes its place
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_left_next  = pend_left_reg;
                            out_right_next = pend_right_reg;
                            out_none_next  = 1'b0;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_left_next  = lo_data_reg;
                        pend_right_next = hi_data_reg;
                        found_next      = found_reg + RW'(1);
                        lo_next         = lo_reg + AW'(1);
                        hi_next         = hi_reg - AW'(1);
                        state_next      = spsf_pkg::ST_READ;
                    end
                end
                else if (pair_sum > key)
                begin
                    hi_next    = hi_reg - AW'(1);
                    state_next = spsf_pkg::ST_READ;
                end
                else
                begin
                    lo_next    = lo_reg + AW'(1);
                    state_next = spsf_pkg::ST_READ;
                end
            end

            // final result of the set
            spsf_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_none_next   = !pend_valid_reg;
                    out_left_next   = pend_valid_reg ? pend_left_reg : '0;
                    out_right_next  = pend_valid_reg ? pend_right_reg : '0;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    state_next      = spsf_pkg::ST_LOAD;
                end
            end

            default:
            begin
                state_next = spsf_pkg::ST_LOAD;
            end
        endcase
    end

    // ports
    assign element_stall = (state_reg != spsf_pkg::ST_LOAD);
    assign cfg_ready     = 1'b1;
    assign result_valid  = out_valid_reg;
    assign left_value    = out_left_reg;
    assign right_value   = out_right_reg;
    assign no_pair       = out_none_reg;
    assign last_result   = out_last_reg;

endmodule

FILE: hw/rtl/spsf_checker.sv
// Port checker for the sorted pair sum finder, bound to the top level.
// Depends on sorted_pair_sum_finder_core_defines.svh and spsf_pkg.
`timescale 1ns / 1ps
`include "sorted_pair_sum_finder_core_defines.svh"

module spsf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             element_valid,
    input logic                             element_stall,
    input logic                             last_element,
    input logic                             result_valid,
    input logic                             result_stall,
    input logic [spsf_pkg::DATA_W-1:0]      left_value,
    input logic [spsf_pkg::DATA_W-1:0]      right_value,
    input logic                             no_pair,
    input logic                             last_result,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);

    // a stalled result request holds
    `SPSF_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(left_value) && $stable(right_value) && $stable(no_pair) && $stable(last_result), "result request changed while stalled")

    // a set with no matching pair reports once, zeroed, as the last result
    `SPSF_ASSERT_IMP(a_no_pair_form, clk, rst_n, result_valid && no_pair, last_result && (left_value == '0) && (right_value == '0), "malformed no_pair result")

    // the marked element starts the search and closes the input
    `SPSF_ASSERT_NXT(a_search_stalls, clk, rst_n, element_valid && !element_stall && last_element, element_stall, "input still open after last element")

    // the configuration port never back-pressures
    `SPSF_ASSERT_IMP(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind sorted_pair_sum_finder_core spsf_checker u_spsf_checker (.*);
